// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: transfer payload types, character
// codes and fixed constants. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int IDX_W  = 11;
  localparam int POSN_W = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;

  // Tab stops every 2**TAB_BITS columns.
  localparam int TAB_BITS = 3;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [POSN_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_value;
  } tcw_rsp_t;

endpackage : tcw_pkg

`default_nettype wire

// ===== rtl/tcw_if.sv =====
// Valid/ready channel interfaces of the text console writer.
// Depends on tcw_pkg for the payload types.
`default_nettype none

interface tcw_req_if;
  logic              valid;
  logic              ready;
  tcw_pkg::tcw_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : tcw_req_if

interface tcw_rsp_if;
  logic              valid;
  logic              ready;
  tcw_pkg::tcw_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : tcw_rsp_if

interface tcw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::ATTR_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : tcw_cfg_if

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : tcw_ram

`default_nettype wire

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer. The screen store (ROWS x COLUMNS cells of 16 bits,
// attribute in the high byte, character in the low byte) lives in one RAM
// with a registered read. Items are handled one at a time; each item
// yields exactly one result (linear cursor position, plus the cell for a
// read). A tab writes one space per column up to the next tab stop (at
// most 8). A newline on the last row scrolls: one RAM read and one
// write-back per cell of rows 1 and up, then the last row is blanked, all
// through the single RAM read and write port. After reset the block sweeps
// the whole store to its reset value before it takes its first item;
// attribute writes are taken at any time. A finished result waits in an
// output register, and the block returns to idle as soon as it is loaded
// there.
// Depends on tcw_pkg, tcw_if.sv and tcw_ram.
`default_nettype none

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic clk,
  input wire logic rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp,
  tcw_cfg_if.sink   cfg
);

  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int LINE_W = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  // Controller state codes.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_CHAR   = 4'd3;
  localparam logic [3:0] S_TAB    = 4'd4;
  localparam logic [3:0] S_BSW    = 4'd5;
  localparam logic [3:0] S_SCROLL = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Control state.
  logic [3:0]        state;
  logic [LINE_W-1:0] line;
  logic [COL_W-1:0]  col;
  logic [ATTR_W-1:0] attribute;
  logic [ADDR_W-1:0] scan;
  logic              mv_pend;
  logic              out_valid;

  // Payload registers.
  logic [CHAR_W-1:0] ch_reg;
  logic [CELL_W-1:0] cell_val;
  logic [ADDR_W-1:0] mv_addr;
  tcw_rsp_t          out_data;

  // RAM ports.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic                  req_fire;
  logic [POS_W-1:0]      pos;
  logic [POS_W+POSN_W-1:0] pos_ext;
  logic [ADDR_W+IDX_W-1:0] idx_ext;
  logic [COL_W-1:0]      col_inc;
  logic                  line_full;
  logic                  on_last_line;
  logic                  tab_end;
  logic                  out_free;

  // Where to go once a newline (possibly with scroll) is out of the way.
  function automatic logic [3:0] after_newline(input logic [CHAR_W-1:0] c);
    logic [3:0] s;
    s = S_CHAR;
    if (c == CH_NEWLINE) begin
      s = S_DONE;
    end else if (c == CH_TAB) begin
      s = S_TAB;
    end
    return s;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign out_free  = !out_valid || rsp.ready;

  // Linear cursor position from the registered line and column.
  assign pos     = POS_W'(line) * POS_W'(COLUMNS) + POS_W'(col);
  assign pos_ext = {{POSN_W{1'b0}}, pos};
  assign idx_ext = {{ADDR_W{1'b0}}, req.data.cell_index};

  assign col_inc      = col + COL_W'(1);
  assign line_full    = (col >= COL_W'(COLUMNS));
  assign on_last_line = (line == LINE_W'(ROWS - 1));
  assign tab_end      = (col_inc[TAB_BITS-1:0] == '0) || (col_inc >= COL_W'(COLUMNS));

  // Read port: cell reads in idle, source cells during a scroll.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan;
    if (req_fire && req.data.kind == KIND_READ) begin
      rd_en   = 1'b1;
      rd_addr = idx_ext[ADDR_W-1:0];
    end else if (state == S_SCROLL) begin
      rd_en = 1'b1;
    end
  end

  // Write port: a pending scroll move wins, else the state's own write.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos[ADDR_W-1:0];
    wr_data = {attribute, CH_SPACE};
    if (mv_pend) begin
      wr_en   = 1'b1;
      wr_addr = mv_addr;
      wr_data = rd_data;
    end else begin
      unique case (state)
        S_CLEAR: begin
          wr_en   = 1'b1;
          wr_addr = scan;
          wr_data = {ATTR_RESET, CH_NUL};
        end
        S_FILL: begin
          wr_en   = 1'b1;
          wr_addr = scan;
        end
        S_CHAR: begin
          wr_en   = 1'b1;
          wr_data = {attribute, ch_reg};
        end
        S_TAB, S_BSW: begin
          wr_en = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      line      <= '0;
      col       <= '0;
      attribute <= ATTR_RESET;
      scan      <= '0;
      mv_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        attribute <= cfg.data;
      end

      // Drop the result once the sink takes it; the done state reloads it.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      // A move issued in the scroll state is written back next cycle.
      mv_pend <= (state == S_SCROLL);

      unique case (state)
        S_CLEAR: begin
          scan <= scan + ADDR_W'(1);
          if (scan == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_fire) begin
            ch_reg   <= req.data.char_code;
            cell_val <= '0;
            if (req.data.kind == KIND_READ) begin
              state <= (idx_ext < (ADDR_W + IDX_W)'(CELLS)) ? S_READ : S_DONE;
            end else begin
              case (req.data.char_code)
                CH_RETURN: begin
                  col   <= '0;
                  state <= S_DONE;
                end
                CH_BACKSPACE: begin
                  if (col == '0 && line == '0) begin
                    state <= S_DONE;
                  end else if (col == '0) begin
                    line  <= line - LINE_W'(1);
                    col   <= COL_W'(COLUMNS - 1);
                    state <= S_BSW;
                  end else begin
                    col   <= col - COL_W'(1);
                    state <= S_BSW;
                  end
                end
                default: begin
                  // Newline, or tab/character on a full line: break first.
                  if (req.data.char_code == CH_NEWLINE || line_full) begin
                    col <= '0;
                    if (!on_last_line) begin
                      line  <= line + LINE_W'(1);
                      state <= after_newline(req.data.char_code);
                    end else begin
                      scan  <= ADDR_W'(COLUMNS);
                      state <= S_SCROLL;
                    end
                  end else begin
                    state <= after_newline(req.data.char_code);
                  end
                end
              endcase
            end
          end
        end

        S_READ: begin
          cell_val <= rd_data;
          state    <= S_DONE;
        end

        S_CHAR: begin
          col   <= col_inc;
          state <= S_DONE;
        end

        S_TAB: begin
          col <= col_inc;
          if (tab_end) begin
            state <= S_DONE;
          end
        end

        S_BSW: begin
          state <= S_DONE;
        end

        S_SCROLL: begin
          // Read cell scan now, write it one row up next cycle.
          mv_addr <= scan - ADDR_W'(COLUMNS);
          if (scan == ADDR_W'(CELLS - 1)) begin
            scan  <= ADDR_W'(CELLS - COLUMNS);
            state <= S_FILL;
          end else begin
            scan <= scan + ADDR_W'(1);
          end
        end

        S_FILL: begin
          // Hold while the last move drains through the write port.
          if (!mv_pend) begin
            scan <= scan + ADDR_W'(1);
            if (scan == ADDR_W'(CELLS - 1)) begin
              state <= after_newline(ch_reg);
            end
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.cursor_position <= pos_ext[POSN_W-1:0];
            out_data.cell_value      <= cell_val;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule : text_console_writer_unit

`default_nettype wire
